### rtl/bpvs_pkg.sv
// Shared types and constants of the Blinn-Phong vertex shader.
// Holds the word structs, configuration layout and pipeline sidebands.
// No dependencies.
package bpvs_pkg;

  localparam int SqSteps  = 25;
  localparam int DivSteps = 30;
  localparam int RadW     = 50;
  localparam int NumW     = 55;

  localparam logic [33:0] HalfMinLen2 = 34'd268;
  localparam logic [29:0] NdothMax    = 30'd671088640;

  typedef enum logic [2:0] {
    REG_AMBIENT  = 3'd0,
    REG_DIFFUSE  = 3'd1,
    REG_LIGHT_X  = 3'd2,
    REG_LIGHT_Y  = 3'd3,
    REG_LIGHT_Z  = 3'd4,
    REG_SPEC     = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] view_x;
    logic signed [15:0] view_y;
    logic signed [15:0] view_z;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_word_t;

  typedef struct packed {
    logic [35:0]        ambient_rgb;
    logic [35:0]        diffuse_rgb;
    logic signed [15:0] light_dir_x;
    logic signed [15:0] light_dir_y;
    logic signed [15:0] light_dir_z;
    logic [10:0]        specular_gain;
  } cfg_t;

  // carried beside the square root
  typedef struct packed {
    logic        spec_en;
    logic [31:0] ndotl;
    logic [32:0] ndoth;
  } sq_side_t;

  // carried beside the divider and the back end
  typedef struct packed {
    logic        spec_en;
    logic [31:0] ndotl;
  } dv_side_t;

endpackage

### rtl/bpvs_front.sv
// Front end: half vector, dot products and squared half-vector length.
// Three register stages. Depends on bpvs_pkg.
module bpvs_front import bpvs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  in_word_t    data_i,
  input  cfg_t        cfg_i,
  output logic        valid_o,
  output logic [RadW-1:0] rad_o,
  output sq_side_t    side_o
);

  logic signed [15:0] n_q [3];
  logic signed [16:0] h_q [3];
  logic signed [31:0] pnl_q [3];
  logic signed [32:0] pnh_q [3];
  logic signed [33:0] phh_q [3];
  logic [2:0]         vld_q;
  logic signed [15:0] l [3];
  logic signed [15:0] v [3];
  logic signed [33:0] ndotl, ndoth;
  logic [33:0]        len2;
  logic [RadW-1:0]    rad_q;
  sq_side_t           side_q;

  assign l[0] = cfg_i.light_dir_x;
  assign l[1] = cfg_i.light_dir_y;
  assign l[2] = cfg_i.light_dir_z;
  assign v[0] = data_i.view_x;
  assign v[1] = data_i.view_y;
  assign v[2] = data_i.view_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q[0] <= data_i.normal_x;
      n_q[1] <= data_i.normal_y;
      n_q[2] <= data_i.normal_z;
      for (int i = 0; i < 3; i++) begin
        h_q[i]   <= 17'(l[i]) + 17'(v[i]);
        pnl_q[i] <= n_q[i] * l[i];
        pnh_q[i] <= n_q[i] * h_q[i];
        phh_q[i] <= h_q[i] * h_q[i];
      end
      rad_q          <= {len2, 16'd0};
      side_q.spec_en <= (len2 > HalfMinLen2) && (ndoth > 34'sd0);
      side_q.ndotl   <= (ndotl > 34'sd0) ? ndotl[31:0] : 32'd0;
      side_q.ndoth   <= (ndoth > 34'sd0) ? ndoth[32:0] : 33'd0;
    end
  end

  assign ndotl = 34'(pnl_q[0]) + 34'(pnl_q[1]) + 34'(pnl_q[2]);
  assign ndoth = 34'(pnh_q[0]) + 34'(pnh_q[1]) + 34'(pnh_q[2]);
  assign len2  = $unsigned(phh_q[0]) + $unsigned(phh_q[1]) + $unsigned(phh_q[2]);

  assign valid_o = vld_q[2];
  assign rad_o   = rad_q;
  assign side_o  = side_q;

endmodule

### rtl/bpvs_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on bpvs_pkg.
module bpvs_sqrt import bpvs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [RadW-1:0] rad_i,
  input  sq_side_t        side_i,
  output logic            valid_o,
  output logic [SqSteps-1:0] root_o,
  output sq_side_t        side_o
);

  logic [SqSteps-1:0] vld_q;
  logic [RadW-1:0]    rem_q  [SqSteps];
  logic [SqSteps-1:0] root_q [SqSteps];
  sq_side_t           side_q [SqSteps];

  for (genvar k = 0; k < SqSteps; k++) begin : g_st
    localparam int Bit = SqSteps - 1 - k;
    logic [RadW-1:0]    rin;
    logic [SqSteps-1:0] qin;
    logic               vin;
    sq_side_t           sin;
    logic [RadW:0]      trial;
    logic [RadW:0]      diff;
    logic               take;

    if (k == 0) begin : g_first
      assign rin = rad_i;
      assign qin = '0;
      assign vin = valid_i;
      assign sin = side_i;
    end else begin : g_next
      assign rin = rem_q[k-1];
      assign qin = root_q[k-1];
      assign vin = vld_q[k-1];
      assign sin = side_q[k-1];
    end

    assign trial = ((RadW+1)'(qin) << (Bit + 1)) | ((RadW+1)'(1) << (2 * Bit));
    assign take  = {1'b0, rin} >= trial;
    assign diff  = {1'b0, rin} - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? diff[RadW-1:0] : rin;
        root_q[k] <= take ? (qin | (SqSteps'(1) << Bit)) : qin;
        side_q[k] <= sin;
      end
    end
  end

  assign valid_o = vld_q[SqSteps-1];
  assign root_o  = root_q[SqSteps-1];
  assign side_o  = side_q[SqSteps-1];

endmodule

### rtl/bpvs_div.sv
// Pipelined restoring divider for N.H: overflow stage, then one quotient bit per stage.
// Depends on bpvs_pkg.
module bpvs_div import bpvs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [SqSteps-1:0] root_i,
  input  sq_side_t           side_i,
  output logic               valid_o,
  output logic [DivSteps-1:0] quot_o,
  output logic               ovf_o,
  output dv_side_t           side_o
);

  logic [DivSteps:0]    vld_q;
  logic [NumW-1:0]      rem_q  [DivSteps+1];
  logic [SqSteps-1:0]   dvs_q  [DivSteps+1];
  logic [DivSteps-1:0]  quot_q [DivSteps+1];
  logic                 ovf_q  [DivSteps+1];
  dv_side_t             side_q [DivSteps+1];
  logic [NumW-1:0]      num;

  assign num = {side_i.ndoth, 22'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num;
      dvs_q[0]  <= root_i;
      quot_q[0] <= '0;
      ovf_q[0]  <= num >= {root_i, {DivSteps{1'b0}}};
      side_q[0] <= '{spec_en: side_i.spec_en, ndotl: side_i.ndotl};
    end
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_st
    localparam int Bit = DivSteps - 1 - k;
    logic [NumW-1:0] trial;
    logic            take;

    assign trial = NumW'(dvs_q[k]) << Bit;
    assign take  = rem_q[k] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= take ? rem_q[k] - trial : rem_q[k];
        quot_q[k+1] <= take ? (quot_q[k] | (DivSteps'(1) << Bit)) : quot_q[k];
        dvs_q[k+1]  <= dvs_q[k];
        ovf_q[k+1]  <= ovf_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = vld_q[DivSteps];
  assign quot_o  = quot_q[DivSteps];
  assign ovf_o   = ovf_q[DivSteps];
  assign side_o  = side_q[DivSteps];

endmodule

### rtl/bpvs_back.sv
// Back end: eighth power of N.H, gains, channel sums and byte conversion.
// Six register stages, the last is the output register. Depends on bpvs_pkg.
module bpvs_back import bpvs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [DivSteps-1:0] quot_i,
  input  logic                ovf_i,
  input  dv_side_t            side_i,
  input  cfg_t                cfg_i,
  output logic                valid_o,
  output out_word_t           data_o
);

  logic [5:0]    vld_q;
  logic [29:0]   x;
  logic [59:0]   xx;
  logic [31:0]   p2_q;
  logic [63:0]   pp;
  logic [29:0]   p4_q;
  logic [59:0]   qq;
  logic [39:0]   spec_q;
  logic [50:0]   sg_q;
  logic [43:0]   difp_q [3];
  logic [51:0]   sum_q  [3];
  logic [7:0]    byte_q [3];
  dv_side_t      s1_q, s2_q, s3_q;
  logic [11:0]   amb [3];
  logic [11:0]   dif [3];
  logic [7:0]    byte_d [3];
  logic [45:0]   scaled [3];

  for (genvar c = 0; c < 3; c++) begin : g_ch
    assign amb[c]    = cfg_i.ambient_rgb[12*c +: 12];
    assign dif[c]    = cfg_i.diffuse_rgb[12*c +: 12];
    assign scaled[c] = {sum_q[c][37:0], 8'd0} - {8'd0, sum_q[c][37:0]};
    assign byte_d[c] = (sum_q[c][51:38] != '0) ? 8'hFF : scaled[c][45:38];
  end

  assign x  = (ovf_i || (quot_i > NdothMax)) ? NdothMax : quot_i;
  assign xx = x * x;
  assign pp = p2_q * p2_q;
  assign qq = p4_q * p4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p2_q   <= xx[59:28];
      s1_q   <= side_i;
      p4_q   <= pp[61:32];
      s2_q   <= s1_q;
      spec_q <= s2_q.spec_en ? qq[59:20] : 40'd0;
      s3_q   <= s2_q;
      sg_q   <= spec_q * cfg_i.specular_gain;
      for (int c = 0; c < 3; c++) begin
        difp_q[c] <= dif[c] * s3_q.ndotl;
        sum_q[c]  <= {amb[c], 28'd0} + 52'(difp_q[c]) + 52'(sg_q);
        byte_q[c] <= byte_d[c];
      end
    end
  end

  assign valid_o      = vld_q[5];
  assign data_o.red   = byte_q[0];
  assign data_o.green = byte_q[1];
  assign data_o.blue  = byte_q[2];

endmodule

### rtl/blinn_phong_vertex_shader.sv
// Blinn-Phong vertex shader, top level.
// Depends on bpvs_pkg, bpvs_front, bpvs_sqrt, bpvs_div and bpvs_back.
//
// Usage:
//   Input channel in_valid_i / stall_o / in_data_i carries a normal and a view
//   vector per word; output channel out_valid_o / stall_i / out_data_o carries
//   one RGB word per input word, in order.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i while
//   the block is idle; unknown indexes are ignored.
// Timing:
//   One word per cycle sustained while the output is not held. A word passes
//   through 3 front stages, 25 square-root stages, 31 divider stages and 6
//   back-end stages before it shows at the output. The square root and divider,
//   one bit per stage, set the depth.
// Reset:
//   Clears all valid bits and loads the default lighting registers.
// Stall:
//   The whole pipeline holds while the output word waits; one more input word
//   is then caught in a skid register and stall_o rises until it drains.
module blinn_phong_vertex_shader import bpvs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        stall_o,
  input  in_word_t    in_data_i,
  output logic        out_valid_o,
  input  logic        stall_i,
  output out_word_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [35:0] cfg_wdata_i
);

  cfg_t               cfg_q;
  logic               en;
  logic               skid_vld_q, skid_vld_d;
  in_word_t           skid_q;
  in_word_t           src;
  logic               src_valid;
  logic               fr_valid;
  logic [RadW-1:0]    fr_rad;
  sq_side_t           fr_side;
  logic               sq_valid;
  logic [SqSteps-1:0] sq_root;
  sq_side_t           sq_side;
  logic               dv_valid;
  logic [DivSteps-1:0] dv_quot;
  logic               dv_ovf;
  dv_side_t           dv_side;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ambient_rgb   <= 36'd3439960218;
      cfg_q.diffuse_rgb   <= 36'd12032619366;
      cfg_q.light_dir_x   <= 16'sd9459;
      cfg_q.light_dir_y   <= 16'sd9459;
      cfg_q.light_dir_z   <= 16'sd9459;
      cfg_q.specular_gain <= 11'd512;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_AMBIENT: cfg_q.ambient_rgb   <= cfg_wdata_i;
        REG_DIFFUSE: cfg_q.diffuse_rgb   <= cfg_wdata_i;
        REG_LIGHT_X: cfg_q.light_dir_x   <= cfg_wdata_i[15:0];
        REG_LIGHT_Y: cfg_q.light_dir_y   <= cfg_wdata_i[15:0];
        REG_LIGHT_Z: cfg_q.light_dir_z   <= cfg_wdata_i[15:0];
        REG_SPEC:    cfg_q.specular_gain <= cfg_wdata_i[10:0];
        default: ;
      endcase
    end
  end

  // advance unless the output word is held
  assign en        = !(out_valid_o && stall_i);
  assign stall_o   = skid_vld_q;
  assign src       = skid_vld_q ? skid_q : in_data_i;
  assign src_valid = skid_vld_q || in_valid_i;

  always_comb begin
    skid_vld_d = skid_vld_q;
    if (en) begin
      skid_vld_d = 1'b0;
    end else if (!skid_vld_q && in_valid_i) begin
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else begin
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && !skid_vld_q && in_valid_i) begin
      skid_q <= in_data_i;
    end
  end

  bpvs_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (src_valid),
    .data_i  (src),
    .cfg_i   (cfg_q),
    .valid_o (fr_valid),
    .rad_o   (fr_rad),
    .side_o  (fr_side)
  );

  bpvs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .rad_i   (fr_rad),
    .side_i  (fr_side),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  bpvs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .root_i  (sq_root),
    .side_i  (sq_side),
    .valid_o (dv_valid),
    .quot_o  (dv_quot),
    .ovf_o   (dv_ovf),
    .side_o  (dv_side)
  );

  bpvs_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_valid),
    .quot_i  (dv_quot),
    .ovf_i   (dv_ovf),
    .side_i  (dv_side),
    .cfg_i   (cfg_q),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_skid_catch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !stall_o && !en |=> skid_vld_q)
    else $error("input word lost while pipeline held");
  a_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q && !en |=> skid_vld_q)
    else $error("skid word dropped while pipeline held");
  a_take_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !stall_i |-> en)
    else $error("output word taken without pipeline advance");
`endif

endmodule

### sim/blinn_phong_vertex_shader_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for blinn_phong_vertex_shader: lights random and corner
// normals and views under several register settings and compares every colour.
// Depends on bpvs_pkg and the block's RTL.
module blinn_phong_vertex_shader_tb;
  import bpvs_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        stall_o;
  in_word_t    in_data_i = '0;
  logic        out_valid_o;
  logic        stall_i = 1'b0;
  out_word_t   out_data_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [35:0] cfg_wdata_i = '0;

  logic [35:0]        amb_q, dif_q;
  logic signed [15:0] lx_q, ly_q, lz_q;
  logic [10:0]        gain_q;

  out_word_t colour_q[$];
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_cycles = 0;
  bit  failed = 1'b0;

  blinn_phong_vertex_shader DUT (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic out_word_t shade(in_word_t w);
    logic signed [63:0] nv[3], hv[3], lv[3];
    logic signed [63:0] ndl, ndh;
    logic [63:0] len2, s, x, p2, p4, spec, sum;
    logic [7:0]  ch[3];
    out_word_t   r;
    lv[0] = 64'(lx_q); lv[1] = 64'(ly_q); lv[2] = 64'(lz_q);
    nv[0] = 64'(w.normal_x); nv[1] = 64'(w.normal_y); nv[2] = 64'(w.normal_z);
    hv[0] = lv[0] + 64'(w.view_x);
    hv[1] = lv[1] + 64'(w.view_y);
    hv[2] = lv[2] + 64'(w.view_z);
    ndl = 0; ndh = 0; len2 = 0; spec = 0;
    for (int i = 0; i < 3; i++) begin
      ndl += nv[i] * lv[i];
      ndh += nv[i] * hv[i];
      len2 += hv[i] * hv[i];
    end
    if (len2 > 268 && ndh > 0) begin
      s = int_sqrt(len2 << 16);
      x = (ndh << 22) / s;
      if (x > (64'd5 << 27)) x = 64'd5 << 27;
      p2 = (x * x) >> 28;
      p4 = ((p2 * p2) >> 28) >> 4;
      spec = (p4 * p4) >> 20;
    end
    for (int i = 0; i < 3; i++) begin
      sum = 64'(amb_q[12*i +: 12]) << 28;
      if (ndl > 0) sum += 64'(dif_q[12*i +: 12]) * ndl;
      sum += spec * gain_q;
      ch[i] = (sum >= (64'd1 << 38)) ? 8'd255 : 8'((sum * 255) >> 38);
    end
    r.red = ch[0]; r.green = ch[1]; r.blue = ch[2];
    return r;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [35:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_AMBIENT: amb_q = val;
      REG_DIFFUSE: dif_q = val;
      REG_LIGHT_X: lx_q = val[15:0];
      REG_LIGHT_Y: ly_q = val[15:0];
      REG_LIGHT_Z: lz_q = val[15:0];
      REG_SPEC:    gain_q = val[10:0];
      default: ;
    endcase
  endtask

  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (stall_o);
    colour_q.push_back(shade(w));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (colour_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // receiver stall: long hold first, random stall otherwise
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !stall_i) begin
      if (colour_q.size() == 0) begin
        $display("%0t: unexpected colour %h", $time, out_data_o);
        failed = 1'b1;
      end else begin
        if (out_data_o !== colour_q[0]) begin
          $display("%0t: colour mismatch expected %h actual %h", $time,
                   colour_q[0], out_data_o);
          failed = 1'b1;
        end
        void'(colour_q.pop_front());
      end
    end
  end

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    w.normal_x = rand_comp(); w.normal_y = rand_comp(); w.normal_z = rand_comp();
    w.view_x = rand_comp(); w.view_y = rand_comp(); w.view_z = rand_comp();
    if ($urandom_range(9) == 0) begin
      w.view_x = 16'(-lx_q + $signed($urandom_range(20)) - 10);
      w.view_y = 16'(-ly_q + $signed($urandom_range(20)) - 10);
      w.view_z = 16'(-lz_q + $signed($urandom_range(20)) - 10);
    end
    return w;
  endfunction

  task automatic test_directed();
    in_word_t w;
    send_word('{16384, 0, 0, 16384, 0, 0});
    send_word('{16384, 16384, 16384, 16384, 16384, 16384});
    send_word('{-16384, -16384, -16384, 0, 0, 0});
    send_word('{9459, 9459, 9459, 9459, 9459, 9459});
    send_word('{9459, 9459, 9459, -9459, -9459, -9459});
    send_word('{9459, 9459, 9459, -9450, -9459, -9459});
    send_word('{-32768, -32768, -32768, -32768, -32768, -32768});
    send_word('{32767, 32767, 32767, 32767, 32767, 32767});
    send_word('{0, 0, 0, 0, 0, 0});
    send_word('{-16384, 0, 0, 16384, 16384, 16384});
    send_word('{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
    send_word('{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555});
    drain();
  endtask

  task automatic test_random(int count, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (count) send_word(rand_word());
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 200;
    repeat (150) send_word(rand_word());
    drain();
  endtask

  task automatic test_settings(int sel);
    case (sel)
      0: begin
        write_reg(REG_AMBIENT, '0); write_reg(REG_DIFFUSE, '0);
        write_reg(REG_SPEC, '0);
      end
      1: begin
        write_reg(REG_AMBIENT, '1); write_reg(REG_DIFFUSE, '1);
        write_reg(REG_SPEC, 36'h7FF);
        write_reg(REG_LIGHT_X, 36'(16'sd16384)); write_reg(REG_LIGHT_Y, '0);
        write_reg(REG_LIGHT_Z, '0);
      end
      2: begin
        write_reg(REG_AMBIENT, 36'd0); write_reg(REG_DIFFUSE, {3{12'd1024}});
        write_reg(REG_SPEC, 36'd1);
        write_reg(REG_LIGHT_X, 36'(-16'sd16384));
        write_reg(REG_LIGHT_Y, 36'h8000); write_reg(REG_LIGHT_Z, 36'h7FFF);
      end
      default: begin
        write_reg(REG_AMBIENT, 36'({$urandom, $urandom} & 36'h0FF0FF0FF));
        write_reg(REG_DIFFUSE, 36'({$urandom, $urandom}));
        write_reg(REG_SPEC, 36'($urandom_range(2047)));
        write_reg(REG_LIGHT_X, 36'(rand_comp()));
        write_reg(REG_LIGHT_Y, 36'(rand_comp()));
        write_reg(REG_LIGHT_Z, 36'(rand_comp()));
      end
    endcase
  endtask

  initial begin
    amb_q = 36'd3439960218; dif_q = 36'd12032619366;
    lx_q = 16'sd9459; ly_q = 16'sd9459; lz_q = 16'sd9459; gain_q = 11'd512;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(300, 0, 0);
    test_random(200, 62, 0);
    test_backpressure();
    for (int k = 0; k < 4; k++) begin
      test_settings(k);
      test_directed();
      test_random(60, 62, 62);
      test_random(60, 16, 16);
    end
    test_settings(3);
    test_random(200, 0, 62);
    if (!failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
